### src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising edge of clk outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// signal that must never be high outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

### src/dpf_pkg.sv
// ----------------------------------------------------------------------------
// dpf_pkg
// Shared constants, state encoding and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dpf_pkg;

	localparam int TABLE_ENTRIES = 10;
	localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int ADDR_W        = 16;
	localparam int STAMP_W       = 32;
	localparam int LEN_W         = 16;

	localparam logic [IDX_W-1:0]  LAST_IDX         = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [ADDR_W-1:0] VACANT_ADDR      = '0;
	localparam logic [LEN_W-1:0]  STAMP_MIN_LENGTH = LEN_W'(4);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic short_pkt;
		logic scan_end;
	} dp_stat_t;

endpackage

### src/dpf_datapath.sv
// ----------------------------------------------------------------------------
// dpf_datapath
// Sender table, one-entry-per-cycle scan, result and output registers.
// ----------------------------------------------------------------------------
module dpf_datapath import dpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic [ADDR_W-1:0]  sender_address,
	input  logic [STAMP_W-1:0] stamp,
	input  logic [LEN_W-1:0]   payload_length,
	output logic               is_duplicate,
	output logic               recorded
);

	logic [ADDR_W-1:0]  entry_address_q [TABLE_ENTRIES];
	logic [STAMP_W-1:0] entry_stamp_q   [TABLE_ENTRIES];

	logic [ADDR_W-1:0]  addr_q;
	logic [STAMP_W-1:0] stamp_q;
	logic               short_q;
	logic [IDX_W-1:0]   idx_q;
	logic               empty_found_q;
	logic [IDX_W-1:0]   empty_idx_q;
	logic               res_dup_q;
	logic               res_rec_q;

	logic [ADDR_W-1:0]  cur_addr;
	logic [STAMP_W-1:0] cur_stamp;
	logic               hit;
	logic               cur_empty;
	logic               last;
	logic               upd_stamp_en;
	logic               new_entry_en;
	logic [IDX_W-1:0]   wr_idx;

	always_comb begin
		cur_addr     = entry_address_q[idx_q];
		cur_stamp    = entry_stamp_q[idx_q];
		hit          = (cur_addr == addr_q);
		cur_empty    = (cur_addr == VACANT_ADDR);
		last         = (idx_q == LAST_IDX);
		upd_stamp_en = cmd.scan && hit && (cur_stamp != stamp_q);
		new_entry_en = cmd.scan && !hit && last && (empty_found_q || cur_empty);
		wr_idx       = empty_found_q ? empty_idx_q : idx_q;
		stat.short_pkt = short_q;
		stat.scan_end  = hit || last;
	end

	// sender table
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TABLE_ENTRIES; k++) begin
				entry_address_q[k] <= VACANT_ADDR;
				entry_stamp_q[k]   <= '0;
			end
		end else if (upd_stamp_en) begin
			entry_stamp_q[idx_q] <= stamp_q;
		end else if (new_entry_en) begin
			entry_address_q[wr_idx] <= addr_q;
			entry_stamp_q[wr_idx]   <= stamp_q;
		end
	end

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q         <= '0;
			empty_found_q <= 1'b0;
			res_dup_q     <= 1'b0;
			res_rec_q     <= 1'b0;
		end else if (cmd.start) begin
			idx_q         <= '0;
			empty_found_q <= 1'b0;
			res_dup_q     <= 1'b0;
			res_rec_q     <= 1'b0;
		end else if (cmd.scan) begin
			if (hit) begin
				res_dup_q <= (cur_stamp == stamp_q);
				res_rec_q <= (cur_stamp != stamp_q);
			end else begin
				if (cur_empty && !empty_found_q) begin
					empty_found_q <= 1'b1;
				end
				if (new_entry_en) begin
					res_rec_q <= 1'b1;
				end
				if (!last) begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	// captured word and first empty slot
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			addr_q      <= sender_address;
			stamp_q     <= stamp;
			short_q     <= (payload_length < STAMP_MIN_LENGTH);
			empty_idx_q <= '0;
		end else if (cmd.scan && !hit && cur_empty && !empty_found_q) begin
			empty_idx_q <= idx_q;
		end
	end

	// output word
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			is_duplicate <= res_dup_q;
			recorded     <= res_rec_q;
		end
	end

endmodule

### src/dpf_ctrl.sv
// ----------------------------------------------------------------------------
// dpf_ctrl
// Controller: input handshake, table scan sequencing and output handshake.
// ----------------------------------------------------------------------------
module dpf_ctrl import dpf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.start = 1'b1;
					state_d   = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (stat.short_pkt) begin
					state_d = ST_FINISH;
				end else begin
					cmd.scan = 1'b1;
					if (stat.scan_end) begin
						state_d = ST_FINISH;
					end
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### src/duplicate_packet_filter_unit.sv
// ----------------------------------------------------------------------------
// duplicate_packet_filter_unit
// Per-sender sequence stamp table that flags repeated forwarded packets.
// ----------------------------------------------------------------------------
// An input word whose payload is shorter than 4 bytes skips the table scan
// and leaves the table unchanged. Otherwise the scan reads one table entry per
// cycle, visiting at most TABLE_ENTRIES entries, finds the first address
// match and the first empty entry in the same pass, and writes at most one
// entry. The result sits in an output register; a new word is taken once the
// previous result has been loaded there. The table clears asynchronously at
// reset.
`include "assert_macros.svh"

module duplicate_packet_filter_unit import dpf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [ADDR_W-1:0]  sender_address,
	input  logic [STAMP_W-1:0] stamp,
	input  logic [LEN_W-1:0]   payload_length,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               is_duplicate,
	output logic               recorded
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	dpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	dpf_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.sender_address (sender_address),
		.stamp          (stamp),
		.payload_length (payload_length),
		.is_duplicate   (is_duplicate),
		.recorded       (recorded)
	);

	`ASSERT_CLK(a_busy_after_accept, (in_valid && !in_stall) |=> in_stall, "word accepted while busy")
	`ASSERT_CLK(a_no_result_overwrite, cmd.out_load |-> (!out_valid || !out_stall), "result lost")
	`ASSERT_NEVER(a_dup_not_recorded, out_valid && is_duplicate && recorded, "duplicate also recorded")

endmodule
